// File: design/mrpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrpp_pkg
// Types, constants and the CRC16 byte step shared by the position poller.
// ----------------------------------------------------------------------------
package mrpp_pkg;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         rx_byte;
      logic [7:0]         axis;
      logic signed [31:0] target_position;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         tx_byte;
      logic               tx_last;
      logic signed [31:0] axis0_position;
      logic signed [31:0] axis1_position;
   } rsp_type;

   localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_WRITE   = 2'd2;

   localparam logic [1:0] CSR_SLAVE_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_AXIS_STRIDE    = 2'd1;
   localparam logic [1:0] CSR_TARGET_OFFSET  = 2'd2;
   localparam logic [1:0] CSR_PRESENT_OFFSET = 2'd3;

   localparam logic [7:0] SLAVE_ADDRESS_RST  = 8'd1;
   localparam logic [7:0] AXIS_STRIDE_RST    = 8'd32;
   localparam logic [7:0] TARGET_OFFSET_RST  = 8'd10;
   localparam logic [7:0] PRESENT_OFFSET_RST = 8'd18;

   localparam logic [7:0] FN_READ        = 8'h03;
   localparam logic [7:0] FN_WRITE_MULTI = 8'h10;
   localparam logic [7:0] REG_COUNT_HI   = 8'h00;
   localparam logic [7:0] REG_COUNT_LO   = 8'h02;
   localparam logic [7:0] DATA_BYTES     = 8'h04;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // transmit frame byte positions
   localparam logic [3:0] TX_IDX_SLAVE     = 4'd0;
   localparam logic [3:0] TX_IDX_FUNC      = 4'd1;
   localparam logic [3:0] TX_IDX_ADDR_HI   = 4'd2;
   localparam logic [3:0] TX_IDX_ADDR_LO   = 4'd3;
   localparam logic [3:0] TX_IDX_CNT_HI    = 4'd4;
   localparam logic [3:0] TX_IDX_CNT_LO    = 4'd5;
   localparam logic [3:0] TX_IDX_BYTES     = 4'd6;
   localparam logic [3:0] TX_IDX_VAL3      = 4'd7;
   localparam logic [3:0] TX_IDX_VAL2      = 4'd8;
   localparam logic [3:0] TX_IDX_VAL1      = 4'd9;
   localparam logic [3:0] TX_IDX_VAL0      = 4'd10;
   localparam logic [3:0] READ_CRC_LO_IDX  = 4'd6;
   localparam logic [3:0] WRITE_CRC_LO_IDX = 4'd11;

   // receive frame byte positions
   localparam logic [3:0] RX_CRC_LO_IDX = 4'd7;
   localparam logic [3:0] RX_LAST_IDX   = 4'd8;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WAIT0 = 2'd1,
      PH_WAIT1 = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_TX     = 2'd1,
      ST_REPORT = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic tx_start;
      logic tx_is_write;
      logic tx_read_axis1;
      logic tx_push;
      logic report_push;
      logic rx_push;
      logic rx_clear;
      logic save_axis0;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic tx_final;
      logic rx_done;
      logic rx_ok;
   } status_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: design/mrpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrpp_ctrl
// Poll phase and sequencing state machine: decides per item which frame,
// report or receive action the datapath performs.
// ----------------------------------------------------------------------------
module mrpp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_func,
   output logic                    req_stall,
   output mrpp_pkg::cmd_type       cmd,
   input  wire mrpp_pkg::status_type status
);
   import mrpp_pkg::*;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           accept;
   logic           waiting;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign waiting   = (phase_ff == PH_WAIT0) || (phase_ff == PH_WAIT1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  state_in = ST_TX;
               end else if (req_func == FUNC_TICK) begin
                  if (phase_ff == PH_IDLE) begin
                     phase_in = PH_WAIT0;
                     state_in = ST_TX;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end else if (req_func == FUNC_RX_BYTE && waiting && status.rx_done) begin
                  priority if (!status.rx_ok) begin
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_WAIT0) begin
                     phase_in = PH_WAIT1;
                     state_in = ST_TX;
                  end else begin
                     phase_in = PH_IDLE;
                     state_in = ST_REPORT;
                  end
               end
            end
         end
         ST_TX: begin
            if (status.slot_free && status.tx_final) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  cmd.tx_start    = 1'b1;
                  cmd.tx_is_write = 1'b1;
               end else if (req_func == FUNC_TICK) begin
                  cmd.rx_clear = 1'b1;
                  cmd.tx_start = (phase_ff == PH_IDLE);
               end else if (req_func == FUNC_RX_BYTE && waiting) begin
                  cmd.rx_push = 1'b1;
                  if (status.rx_done && status.rx_ok && phase_ff == PH_WAIT0) begin
                     cmd.save_axis0    = 1'b1;
                     cmd.tx_start      = 1'b1;
                     cmd.tx_read_axis1 = 1'b1;
                  end
               end
            end
         end
         ST_TX: begin
            cmd.tx_push = status.slot_free;
         end
         ST_REPORT: begin
            cmd.report_push = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/mrpp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrpp_dp
// Datapath: configuration registers, frame builder with CRC16, receive
// collector with running CRC, and the result output register.
// ----------------------------------------------------------------------------
module mrpp_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_wdata,
   input  wire mrpp_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output mrpp_pkg::rsp_type         rsp_data,
   input  wire mrpp_pkg::cmd_type    cmd,
   output mrpp_pkg::status_type      status
);
   import mrpp_pkg::*;

   logic [7:0]  slave_ff, stride_ff, target_off_ff, present_off_ff;

   logic [15:0] addr_ff, addr_in;
   logic [31:0] target_ff, target_in;
   logic        is_write_ff, is_write_in;
   logic [3:0]  tx_idx_ff, tx_idx_in;
   logic [15:0] tx_crc_ff, tx_crc_in;

   logic [7:0]  rx_frame_ff [8];
   logic [7:0]  rx_frame_in [8];
   logic [3:0]  rx_count_ff, rx_count_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [31:0] saved_axis0_ff, saved_axis0_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [7:0]  axis_sel, offset_sel;
   logic [15:0] addr_calc;
   logic [3:0]  crc_lo_idx, last_idx;
   logic [7:0]  data_byte, tx_byte;
   logic        header_hit;
   logic [15:0] rx_crc_src, rx_crc_step;
   logic [31:0] rx_raw;
   logic        slot_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff       <= SLAVE_ADDRESS_RST;
         stride_ff      <= AXIS_STRIDE_RST;
         target_off_ff  <= TARGET_OFFSET_RST;
         present_off_ff <= PRESENT_OFFSET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:  slave_ff       <= csr_wdata;
            CSR_AXIS_STRIDE:    stride_ff      <= csr_wdata;
            CSR_TARGET_OFFSET:  target_off_ff  <= csr_wdata;
            CSR_PRESENT_OFFSET: present_off_ff <= csr_wdata;
            default:            slave_ff       <= slave_ff;
         endcase
      end
   end

   // register address of the frame being started
   always_comb begin
      priority if (cmd.tx_is_write) begin
         axis_sel = req_data.axis;
      end else if (cmd.tx_read_axis1) begin
         axis_sel = 8'd1;
      end else begin
         axis_sel = 8'd0;
      end
      offset_sel = cmd.tx_is_write ? target_off_ff : present_off_ff;
      addr_calc  = ({8'h00, axis_sel} * {8'h00, stride_ff}) + {8'h00, offset_sel};
   end

   // frame byte select
   assign crc_lo_idx = is_write_ff ? WRITE_CRC_LO_IDX : READ_CRC_LO_IDX;
   assign last_idx   = crc_lo_idx + 4'd1;

   always_comb begin
      unique case (tx_idx_ff)
         TX_IDX_SLAVE:   data_byte = slave_ff;
         TX_IDX_FUNC:    data_byte = is_write_ff ? FN_WRITE_MULTI : FN_READ;
         TX_IDX_ADDR_HI: data_byte = addr_ff[15:8];
         TX_IDX_ADDR_LO: data_byte = addr_ff[7:0];
         TX_IDX_CNT_HI:  data_byte = REG_COUNT_HI;
         TX_IDX_CNT_LO:  data_byte = REG_COUNT_LO;
         TX_IDX_BYTES:   data_byte = DATA_BYTES;
         TX_IDX_VAL3:    data_byte = target_ff[31:24];
         TX_IDX_VAL2:    data_byte = target_ff[23:16];
         TX_IDX_VAL1:    data_byte = target_ff[15:8];
         TX_IDX_VAL0:    data_byte = target_ff[7:0];
         default:        data_byte = 8'h00;
      endcase
      priority if (tx_idx_ff == last_idx) begin
         tx_byte = tx_crc_ff[15:8];
      end else if (tx_idx_ff == crc_lo_idx) begin
         tx_byte = tx_crc_ff[7:0];
      end else begin
         tx_byte = data_byte;
      end
   end

   // transmit sequencing
   always_comb begin
      addr_in     = addr_ff;
      target_in   = target_ff;
      is_write_in = is_write_ff;
      tx_idx_in   = tx_idx_ff;
      tx_crc_in   = tx_crc_ff;
      if (cmd.tx_start) begin
         addr_in     = addr_calc;
         target_in   = req_data.target_position;
         is_write_in = cmd.tx_is_write;
         tx_idx_in   = '0;
         tx_crc_in   = CRC_INIT;
      end else if (cmd.tx_push) begin
         tx_idx_in = tx_idx_ff + 4'd1;
         if (tx_idx_ff < crc_lo_idx) begin
            tx_crc_in = crc16_byte(tx_crc_ff, data_byte);
         end
      end
   end

   // receive collector
   assign header_hit  = (rx_frame_ff[0] == slave_ff) && (req_data.rx_byte == FN_READ);
   assign rx_crc_src  = ((rx_count_ff == 4'd0) || (rx_count_ff == 4'd1 && !header_hit))
                        ? CRC_INIT : rx_crc_ff;
   assign rx_crc_step = crc16_byte(rx_crc_src, req_data.rx_byte);
   assign rx_raw      = {rx_frame_ff[3], rx_frame_ff[4], rx_frame_ff[5], rx_frame_ff[6]};

   always_comb begin
      rx_frame_in = rx_frame_ff;
      rx_count_in = rx_count_ff;
      rx_crc_in   = rx_crc_ff;
      if (cmd.rx_clear) begin
         rx_count_in = '0;
      end else if (cmd.rx_push) begin
         priority if (rx_count_ff == 4'd0) begin
            rx_frame_in[0] = req_data.rx_byte;
            rx_crc_in      = rx_crc_step;
            rx_count_in    = 4'd1;
         end else if (rx_count_ff == 4'd1) begin
            rx_crc_in = rx_crc_step;
            if (header_hit) begin
               rx_frame_in[1] = req_data.rx_byte;
               rx_count_in    = 4'd2;
            end else begin
               rx_frame_in[0] = req_data.rx_byte;
            end
         end else if (rx_count_ff == RX_LAST_IDX) begin
            rx_count_in = '0;
         end else begin
            rx_frame_in[rx_count_ff[2:0]] = req_data.rx_byte;
            rx_count_in                   = rx_count_ff + 4'd1;
            if (rx_count_ff != RX_CRC_LO_IDX) begin
               rx_crc_in = rx_crc_step;
            end
         end
      end
   end

   assign saved_axis0_in = cmd.save_axis0 ? rx_raw : saved_axis0_ff;

   // result register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.tx_push) begin
         rsp_valid_in          = 1'b1;
         rsp_in                = '0;
         rsp_in.tx_byte        = tx_byte;
         rsp_in.tx_last        = (tx_idx_ff == last_idx);
      end else if (cmd.report_push) begin
         rsp_valid_in          = 1'b1;
         rsp_in                = '0;
         rsp_in.kind           = 1'b1;
         rsp_in.axis0_position = saved_axis0_ff;
         rsp_in.axis1_position = rx_raw;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff    <= '0;
         saved_axis0_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         tx_idx_ff      <= '0;
         is_write_ff    <= 1'b0;
      end else begin
         rx_count_ff    <= rx_count_in;
         saved_axis0_ff <= saved_axis0_in;
         rsp_valid_ff   <= rsp_valid_in;
         tx_idx_ff      <= tx_idx_in;
         is_write_ff    <= is_write_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      target_ff   <= target_in;
      tx_crc_ff   <= tx_crc_in;
      rx_frame_ff <= rx_frame_in;
      rx_crc_ff   <= rx_crc_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.slot_free = slot_free;
   assign status.tx_final  = (tx_idx_ff == last_idx);
   assign status.rx_done   = (rx_count_ff == RX_LAST_IDX);
   assign status.rx_ok     = (rx_frame_ff[2] == DATA_BYTES) &&
                             (rx_crc_ff == {req_data.rx_byte, rx_frame_ff[7]});

   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RX_LAST_IDX)
      else $error("receive count past frame end");

   // index rests one past the final byte once a frame is done
   a_tx_idx_range: assert property (@(posedge clock) disable iff (reset)
      tx_idx_ff <= WRITE_CRC_LO_IDX + 4'd2)
      else $error("transmit index past frame end");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.tx_push && status.tx_final |=> rsp_valid_ff && rsp_ff.tx_last && !rsp_ff.kind)
      else $error("final frame byte not flagged");

   a_report_kind: assert property (@(posedge clock) disable iff (reset)
      cmd.report_push |=> rsp_valid_ff && rsp_ff.kind && !rsp_ff.tx_last)
      else $error("report transfer malformed");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.tx_push || cmd.report_push) |-> slot_free && !(cmd.tx_push && cmd.report_push))
      else $error("push into occupied result register");

endmodule
`default_nettype wire

// File: design/modbus_rtu_position_poller.sv
`timescale 1ns / 1ps
`default_nettype none
// first frame byte: registered frame start, then pushed once the result
// register is free; throughput: one frame byte per cycle while rsp_stall is
// low; req_stall holds until a frame's final byte or a report is pushed;
// received bytes and ticks that start no frame or report leave req_stall low
// reset: synchronous, clears poll phase, receive count, saved axis 0 and
// restores the register defaults; no clearing pass
// ----------------------------------------------------------------------------
// modbus_rtu_position_poller
// Modbus RTU master polling two axis positions and writing axis targets,
// with CRC16 generation and response checking.
// ----------------------------------------------------------------------------
module modbus_rtu_position_poller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mrpp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mrpp_pkg::rsp_type      rsp_data
);
   import mrpp_pkg::*;

   cmd_type    cmd;
   status_type status;

   mrpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mrpp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire
